@@ rtl/spq_pkg.sv @@
// Shared types, codes and command/status structs for the sorted priority packet queue.
package spq_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     id;
  } entry_t;

  typedef enum logic [2:0] {
    POS_HOLD  = 3'd0,
    POS_LOAD  = 3'd1,
    POS_CLEAR = 3'd2,
    POS_INC   = 3'd3,
    POS_DEC   = 3'd4
  } pos_op_t;

  typedef struct packed {
    logic    load_req;
    pos_op_t pos_op;
    logic    rd_up;
    logic    wr_en;
    logic    wr_prev;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    head_load;
    logic    head_clear;
    logic    status_load;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic pos_lt_count;
    logic shift_cond;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/spq_dpath.sv @@
// Datapath: entry memory, position and count registers, head capture and output register.
module spq_dpath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::entry_t                      in_entry,
  input  spq_pkg::cmd_t                        cmd,
  output spq_pkg::stat_t                       stat,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output spq_pkg::status_t                     out_status,
  output spq_pkg::entry_t                      out_entry,
  output logic [spq_pkg::FILL_W-1:0]           out_fill
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = $clog2(DEPTH + 1);

  spq_pkg::entry_t  mem [DEPTH];
  spq_pkg::entry_t  rdata;
  spq_pkg::entry_t  req;
  spq_pkg::entry_t  head;
  spq_pkg::status_t st_code;
  logic [PW-1:0]    pos, pos_next;
  logic [PW-1:0]    count;
  logic [PW-1:0]    rd_pos, wr_pos;
  logic [IW-1:0]    raddr, waddr;
  spq_pkg::entry_t  wdata;

  always_comb begin
    unique case (cmd.pos_op)
      spq_pkg::POS_HOLD:  pos_next = pos;
      spq_pkg::POS_LOAD:  pos_next = count;
      spq_pkg::POS_CLEAR: pos_next = '0;
      spq_pkg::POS_INC:   pos_next = pos + 1'b1;
      spq_pkg::POS_DEC:   pos_next = pos - 1'b1;
      default:            pos_next = pos;
    endcase
  end

  // read at the next position, or one below it unless rd_up; out-of-range reads are don't-care
  assign rd_pos = cmd.rd_up ? pos_next : pos_next - 1'b1;
  assign raddr  = (rd_pos < PW'(DEPTH)) ? rd_pos[IW-1:0] : '0;
  assign wr_pos = cmd.wr_prev ? pos - 1'b1 : pos;
  assign waddr  = wr_pos[IW-1:0];
  assign wdata  = cmd.wr_new ? req : rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (cmd.load_req) begin
      req <= in_entry;
    end
    if (cmd.head_clear) begin
      head <= '0;
    end else if (cmd.head_load) begin
      head <= rdata;
    end
    if (cmd.status_load) begin
      st_code <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status <= st_code;
      out_entry  <= head;
      out_fill   <= spq_pkg::FILL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.full         = (count == PW'(DEPTH));
  assign stat.empty        = (count == '0);
  assign stat.pos_zero     = (pos == '0);
  assign stat.pos_lt_count = (pos < count);
  assign stat.shift_cond   = (rdata.prio > req.prio);
  assign stat.out_free     = !m_tvalid || m_tready;

endmodule

@@ rtl/spq_ctrl.sv @@
// Controller: sequences enqueue shifts, head reads and dequeue shifts.
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  spq_pkg::func_t req_func,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_HEAD  = 5'b00100,
    S_UP    = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   is_peek, is_peek_next;
  logic   accept;

  // hold off the sender while reset is applied
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    is_peek_next = is_peek;
    cmd          = '0;
    cmd.pos_op   = spq_pkg::POS_HOLD;
    cmd.status   = spq_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req    = 1'b1;
          cmd.status_load = 1'b1;
          cmd.head_clear  = 1'b1;
          is_peek_next    = (req_func == spq_pkg::FN_PEEK);
          unique case (req_func)
            spq_pkg::FN_ENQ: begin
              if (stat.full) begin
                cmd.status = spq_pkg::ST_OVERFLOW;
                state_next = S_RESP;
              end else begin
                cmd.pos_op = spq_pkg::POS_LOAD;
                state_next = S_SHIFT;
              end
            end
            spq_pkg::FN_DEQ, spq_pkg::FN_PEEK: begin
              if (stat.empty) begin
                cmd.status = spq_pkg::ST_EMPTY;
                state_next = S_RESP;
              end else begin
                cmd.pos_op = spq_pkg::POS_CLEAR;
                cmd.rd_up  = 1'b1;
                state_next = S_HEAD;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.wr_en = 1'b1;
        if (!stat.pos_zero && stat.shift_cond) begin
          // move the larger-priority entry up one slot
          cmd.pos_op = spq_pkg::POS_DEC;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_HEAD: begin
        cmd.head_load = 1'b1;
        if (is_peek) begin
          state_next = S_RESP;
        end else begin
          cmd.pos_op = spq_pkg::POS_INC;
          cmd.rd_up  = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (stat.pos_lt_count) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_prev = 1'b1;
          cmd.pos_op  = spq_pkg::POS_INC;
          cmd.rd_up   = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_RESP: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_peek <= 1'b0;
    end else begin
      state   <= state_next;
      is_peek <= is_peek_next;
    end
  end

endmodule

@@ rtl/sorted_priority_packet_queue_unit.sv @@
// Top level of the sorted priority packet queue: ports, field packing and checks.
//
// Requests arrive as words on the s_ channel: s_tuser carries the request kind
// (enqueue, dequeue, peek), s_tdata the descriptor to enqueue. Each request
// gives exactly one result word on the m_ channel: m_tuser is the status code,
// m_tdata the returned head entry and the fill level after the request.
// Entries are held in one memory kept sorted by priority, smallest first,
// equal priorities in arrival order. One request is worked at a time: an
// enqueue moves the entries with larger priority than the new one up one
// slot, a dequeue moves every entry behind the head down one slot, and a
// peek, an overflow, an empty result or an unused kind moves none. The
// memory has a single port pair, so one entry is moved per cycle.
// s_tready is high only while no request is in work. The result sits in an
// output register; the next request is accepted while it waits, and that
// request stalls at its end until m_tready takes the earlier word.
// Reset clears the entry count and the result valid; memory contents are not
// cleared and are never read above the count, so no clearing pass is needed.
module sorted_priority_packet_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // packet_id [15:0], packet_kind [18:16], payload_handle [34:19], prio_level [37:35]
  input  logic [spq_pkg::IN_DATA_W-1:0]      s_tdata,
  // func [1:0]
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_id [15:0], out_kind [18:16], out_handle [34:19], out_prio [37:35],
  // fill_level [45:38]
  output logic [spq_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status [1:0]
  output logic [1:0]                         m_tuser
);

  spq_pkg::entry_t  in_entry;
  spq_pkg::entry_t  out_entry;
  spq_pkg::status_t out_status;
  logic [spq_pkg::FILL_W-1:0] out_fill;
  spq_pkg::cmd_t    cmd;
  spq_pkg::stat_t   stat;

  assign in_entry.id     = s_tdata[15:0];
  assign in_entry.kind   = s_tdata[18:16];
  assign in_entry.handle = s_tdata[34:19];
  assign in_entry.prio   = s_tdata[37:35];

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_func (spq_pkg::func_t'(s_tuser)),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_dpath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_entry   (in_entry),
    .cmd        (cmd),
    .stat       (stat),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_fill   (out_fill)
  );

  assign m_tdata = {2'b00, out_fill, out_entry.prio, out_entry.handle,
                    out_entry.kind, out_entry.id};
  assign m_tuser = out_status;

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  // a stalled result is never overwritten by a finishing request
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !cmd.out_load)
    else $error("result overwritten while stalled");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == spq_pkg::ST_OVERFLOW) |->
      (m_tdata[45:38] == spq_pkg::FILL_W'(QUEUE_DEPTH)) && (m_tdata[37:0] == '0))
    else $error("overflow reported below full depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) |-> (m_tdata == '0))
    else $error("empty result carries data");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("count both full and empty");

endmodule
